[rtl/core/hndm_pkg.sv]
// Shared types, constants and the popcount helper for the Hamming descriptor matcher.
`default_nettype none

package hndm_pkg;

	// Field widths fixed by the item formats.
	localparam int OPCODE_W  = 2;
	localparam int QIDX_W    = 12;
	localparam int WORD_W    = 64;
	localparam int DESC_W    = 256;
	localparam int REF_W     = 11;
	localparam int DIST_W    = 9;
	localparam int THR_W     = 9;
	localparam int CHUNK_W   = 32;
	localparam int CHUNKS    = DESC_W / CHUNK_W;
	localparam int CHUNK_CNT_W = 6;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 9'd50;

	// Input opcodes.
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

	// Queue between front and back.
	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_FILL_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	// One classified command as it travels from front to back.
	typedef struct packed {
		kind_t              kind;
		logic               corner;
		logic [QIDX_W-1:0]  qidx;
		logic [DESC_W-1:0]  desc;
	} cmd_t;

	// Set-bit count of a 32-bit word by the usual mask-and-add reduction.
	function automatic logic [CHUNK_CNT_W-1:0] popcount32(input logic [CHUNK_W-1:0] v);
		logic [CHUNK_W-1:0] a;
		logic [CHUNK_W-1:0] b;
		logic [CHUNK_W-1:0] c;
		logic [CHUNK_CNT_W-1:0] s;
		a = v - ((v >> 1) & 32'h5555_5555);
		b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
		c = (b + (b >> 4)) & 32'h0F0F_0F0F;
		s = CHUNK_CNT_W'(c[7:0]) + CHUNK_CNT_W'(c[15:8])
			+ CHUNK_CNT_W'(c[23:16]) + CHUNK_CNT_W'(c[31:24]);
		return s;
	endfunction

endpackage

`default_nettype wire

[rtl/core/hndm_front.sv]
// Front end: accepts input beats, drops those without effect, and queues the rest.
`default_nettype none

module hndm_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [hndm_pkg::OPCODE_W-1:0]     opcode,
	input  wire logic                              is_corner,
	input  wire logic [hndm_pkg::QIDX_W-1:0]       query_index,
	input  wire logic [hndm_pkg::WORD_W-1:0]       desc_word0,
	input  wire logic [hndm_pkg::WORD_W-1:0]       desc_word1,
	input  wire logic [hndm_pkg::WORD_W-1:0]       desc_word2,
	input  wire logic [hndm_pkg::WORD_W-1:0]       desc_word3,
	output hndm_pkg::cmd_t                         cmd,
	output logic                                   cmd_valid,
	input  wire logic                              cmd_pop
);

	hndm_pkg::cmd_t                         entry_q [hndm_pkg::QUEUE_DEPTH];
	logic [hndm_pkg::QUEUE_PTR_W-1:0]       wr_ptr_q;
	logic [hndm_pkg::QUEUE_PTR_W-1:0]       rd_ptr_q;
	logic [hndm_pkg::QUEUE_FILL_W-1:0]      fill_q;
	hndm_pkg::cmd_t                         new_cmd;
	logic                                   keep;
	logic                                   push;
	logic                                   pop;

	// Classify the beat; unused opcodes and non-corner queries leave no trace.
	always_comb begin
		new_cmd.corner = is_corner;
		new_cmd.qidx   = query_index;
		new_cmd.desc   = {desc_word3, desc_word2, desc_word1, desc_word0};
		new_cmd.kind   = hndm_pkg::KIND_CLEAR;
		keep           = 1'b0;
		unique case (opcode)
			hndm_pkg::OP_CLEAR: begin
				new_cmd.kind = hndm_pkg::KIND_CLEAR;
				keep         = 1'b1;
			end
			hndm_pkg::OP_APPEND: begin
				new_cmd.kind = hndm_pkg::KIND_APPEND;
				keep         = 1'b1;
			end
			hndm_pkg::OP_QUERY: begin
				new_cmd.kind = hndm_pkg::KIND_QUERY;
				keep         = is_corner;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall  = (fill_q == hndm_pkg::QUEUE_FILL_W'(hndm_pkg::QUEUE_DEPTH));
	assign push      = in_valid && !in_stall && keep;
	assign cmd_valid = (fill_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/hndm_back.sv]
// Back end: reference memory, scan pipeline with popcount, best-match tracking and result register.
`default_nettype none

module hndm_back #(
	parameter int MAX_REFERENCES = 2048
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  hndm_pkg::cmd_t                       cmd,
	input  wire logic                            cmd_valid,
	output logic                                 cmd_pop,
	input  wire logic [hndm_pkg::THR_W-1:0]      threshold,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [hndm_pkg::QIDX_W-1:0]          match_query,
	output logic [hndm_pkg::REF_W-1:0]           match_reference,
	output logic [hndm_pkg::DIST_W-1:0]          match_distance
);

	localparam int IDXW = $clog2(MAX_REFERENCES);
	localparam int CNTW = $clog2(MAX_REFERENCES + 1);
	localparam logic [CNTW-1:0] CAPACITY = CNTW'(MAX_REFERENCES);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	// Each entry holds the corner flag above the descriptor.
	logic [hndm_pkg::DESC_W:0]               mem [MAX_REFERENCES];

	logic [1:0]                              state_q;
	logic [CNTW-1:0]                         count_q;
	logic [CNTW-1:0]                         issue_q;
	logic [hndm_pkg::DESC_W-1:0]             qdesc_q;
	logic [hndm_pkg::QIDX_W-1:0]             qidx_q;

	logic                                    mem_we;
	logic                                    mem_re;
	logic [hndm_pkg::DESC_W:0]               rd_word_s1;
	logic                                    v_s1;
	logic [IDXW-1:0]                         idx_s1;
	logic [hndm_pkg::DESC_W-1:0]             diff;

	logic                                    v_s2;
	logic [IDXW-1:0]                         idx_s2;
	logic [hndm_pkg::CHUNK_CNT_W-1:0]        cnt_s2 [hndm_pkg::CHUNKS];

	logic                                    v_s3;
	logic [IDXW-1:0]                         idx_s3;
	logic [hndm_pkg::DIST_W-1:0]             dist_s3;
	logic [hndm_pkg::DIST_W-1:0]             dist_sum;

	logic                                    found_q;
	logic [hndm_pkg::DIST_W-1:0]             best_dist_q;
	logic [IDXW-1:0]                         best_idx_q;
	logic [IDXW+hndm_pkg::REF_W-1:0]         best_idx_ext;

	logic                                    out_valid_q;
	logic                                    out_free;
	logic                                    is_match;
	logic                                    load_out;

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign mem_we   = cmd_pop && (cmd.kind == hndm_pkg::KIND_APPEND) && (count_q < CAPACITY);
	assign mem_re   = (state_q == ST_SCAN) && (issue_q < count_q);
	assign out_free = !out_valid_q || !out_stall;
	assign is_match = found_q && (best_dist_q < threshold);
	assign load_out = (state_q == ST_FINISH) && is_match && out_free;
	assign diff     = rd_word_s1[hndm_pkg::DESC_W-1:0] ^ qdesc_q;

	always_comb begin
		dist_sum = '0;
		for (int k = 0; k < hndm_pkg::CHUNKS; k++) begin
			dist_sum = dist_sum + hndm_pkg::DIST_W'(cnt_s2[k]);
		end
	end

	assign best_idx_ext = {{hndm_pkg::REF_W{1'b0}}, best_idx_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[IDXW-1:0]] <= {cmd.corner, cmd.desc};
		end
		if (mem_re) begin
			rd_word_s1 <= mem[issue_q[IDXW-1:0]];
		end
	end

	// Payload registers of the scan pipeline, the query and the result.
	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.kind == hndm_pkg::KIND_QUERY)) begin
			qdesc_q <= cmd.desc;
			qidx_q  <= cmd.qidx;
		end
		idx_s1 <= issue_q[IDXW-1:0];
		idx_s2 <= idx_s1;
		for (int k = 0; k < hndm_pkg::CHUNKS; k++) begin
			cnt_s2[k] <= hndm_pkg::popcount32(diff[k*hndm_pkg::CHUNK_W +: hndm_pkg::CHUNK_W]);
		end
		idx_s3  <= idx_s2;
		dist_s3 <= dist_sum;
		if (load_out) begin
			match_query     <= qidx_q;
			match_reference <= best_idx_ext[hndm_pkg::REF_W-1:0];
			match_distance  <= best_dist_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			issue_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			found_q     <= 1'b0;
			best_dist_q <= '0;
			best_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= mem_re;
			v_s2 <= v_s1 && rd_word_s1[hndm_pkg::DESC_W];
			v_s3 <= v_s2;

			// Strict compare keeps the earliest reference on a tie.
			if (v_s3 && (!found_q || (dist_s3 < best_dist_q))) begin
				found_q     <= 1'b1;
				best_dist_q <= dist_s3;
				best_idx_q  <= idx_s3;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.kind)
							hndm_pkg::KIND_CLEAR: begin
								count_q <= '0;
							end
							hndm_pkg::KIND_APPEND: begin
								if (count_q < CAPACITY) begin
									count_q <= count_q + 1'b1;
								end
							end
							hndm_pkg::KIND_QUERY: begin
								issue_q <= '0;
								found_q <= 1'b0;
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						issue_q <= issue_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!is_match || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAPACITY)
		else $error("reference count exceeds capacity");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("scan pipeline busy while back end is idle");

	a_result_below_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && (match_distance < threshold)))
		else $error("result issued with distance not below threshold");

	a_scan_within_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issue_q <= count_q))
		else $error("scan address ran past the reference count");

endmodule

`default_nettype wire

[rtl/core/hamming_nearest_descriptor_match_core.sv]
// Brute-force Hamming matcher top: config port, front end, two-entry queue and back end.
// Clear and append beats take effect one cycle after acceptance when the back end is idle.
// A query holds the back end while it scans the stored references at one reference per cycle,
// drains the scan pipeline and finishes, and longer while a match beat waits; queries run
// one at a time.
// Reset clears count, queue and result valid flag and sets the threshold to 50, memory untouched.
`default_nettype none

module hamming_nearest_descriptor_match_core #(
	parameter int MAX_REFERENCES = 2048
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	// Configuration port.
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [hndm_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [hndm_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [hndm_pkg::APB_DATA_W-1:0]          prdata,
	output logic                                     pready,

	// Input channel.
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [hndm_pkg::OPCODE_W-1:0]       opcode,
	input  wire logic                                is_corner,
	input  wire logic [hndm_pkg::QIDX_W-1:0]         query_index,
	input  wire logic [hndm_pkg::WORD_W-1:0]         desc_word0,
	input  wire logic [hndm_pkg::WORD_W-1:0]         desc_word1,
	input  wire logic [hndm_pkg::WORD_W-1:0]         desc_word2,
	input  wire logic [hndm_pkg::WORD_W-1:0]         desc_word3,

	// Output channel.
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [hndm_pkg::QIDX_W-1:0]              match_query,
	output logic [hndm_pkg::REF_W-1:0]               match_reference,
	output logic [hndm_pkg::DIST_W-1:0]              match_distance
);

	logic [hndm_pkg::THR_W-1:0]  threshold_q;
	logic                        cfg_write;
	logic                        reg_sel;
	hndm_pkg::cmd_t              cmd;
	logic                        cmd_valid;
	logic                        cmd_pop;

	// The register index is the word address; byte offsets within the word are ignored.
	// Only one register exists, so a write to any other word is dropped.
	assign reg_sel   = paddr[hndm_pkg::APB_ADDR_W-1];
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= hndm_pkg::THRESHOLD_RESET;
		end else if (cfg_write && (reg_sel == hndm_pkg::REG_THRESHOLD)) begin
			threshold_q <= pwdata[hndm_pkg::THR_W-1:0];
		end
	end

	always_comb begin
		if (reg_sel == hndm_pkg::REG_THRESHOLD) begin
			prdata = hndm_pkg::APB_DATA_W'(threshold_q);
		end else begin
			prdata = '0;
		end
	end

	// The front end classifies each beat and parks useful commands in a two-entry queue,
	// so new beats are taken while the back end is still scanning or a result waits, until the queue is full.
	hndm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.is_corner   (is_corner),
		.query_index (query_index),
		.desc_word0  (desc_word0),
		.desc_word1  (desc_word1),
		.desc_word2  (desc_word2),
		.desc_word3  (desc_word3),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop)
	);

	// The back end owns the reference memory, walks it one entry per cycle for a query,
	// and holds the result in its output register until the consumer takes it.
	hndm_back #(
		.MAX_REFERENCES (MAX_REFERENCES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cmd_valid       (cmd_valid),
		.cmd_pop         (cmd_pop),
		.threshold       (threshold_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.match_query     (match_query),
		.match_reference (match_reference),
		.match_distance  (match_distance)
	);

endmodule

`default_nettype wire

[tb/sv/hamming_nearest_descriptor_match_core_tb.sv]
// Self-checking testbench for the brute-force Hamming descriptor matcher core.
`default_nettype none

module hamming_nearest_descriptor_match_core_tb;
	import hndm_pkg::*;

	// Capacity of the reference store, as in the default build of the core.
	localparam int MAX_REFS = 2048;

	// Number of references loaded by the long store test.
	localparam int STORE_FILL = 60;

	// Byte addresses on the configuration port: the threshold register sits at
	// index 0, and index 1 has no register behind it.
	localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = 3'd0;
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR     = 3'd4;

	// The one opcode value that the core must ignore.
	localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

	// Percentages for the idling phases.
	localparam int HEAVY_PCT = 68;
	localparam int LIGHT_PCT = 11;

	// Generous ceiling on the whole run, in clock cycles.
	localparam int WATCHDOG_CYCLES = 2_000_000;

	// One expected match beat.
	typedef struct {
		logic [QIDX_W-1:0] qidx;
		logic [REF_W-1:0]  ref_pos;
		logic [DIST_W-1:0] dist_val;
	} match_t;

	// Every input starts at a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OPCODE_W-1:0] opcode = '0;
	logic is_corner = 1'b0;
	logic [QIDX_W-1:0] query_index = '0;
	logic [WORD_W-1:0] desc_word0 = '0;
	logic [WORD_W-1:0] desc_word1 = '0;
	logic [WORD_W-1:0] desc_word2 = '0;
	logic [WORD_W-1:0] desc_word3 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [QIDX_W-1:0] match_query;
	logic [REF_W-1:0] match_reference;
	logic [DIST_W-1:0] match_distance;

	// Idling knobs, changed from phase to phase by the test sequence.
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	int fail_count = 0;

	// Our own copy of the reference store, its fill level and the threshold.
	logic [DESC_W-1:0] mirror_desc [MAX_REFS];
	bit mirror_corner [MAX_REFS];
	int unsigned mirror_count = 0;
	logic [THR_W-1:0] mirror_threshold = THRESHOLD_RESET;

	// Match beats predicted but not yet seen on the output, oldest first.
	match_t pending_matches[$];

	hamming_nearest_descriptor_match_core #(
		.MAX_REFERENCES(MAX_REFS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.is_corner(is_corner),
		.query_index(query_index),
		.desc_word0(desc_word0),
		.desc_word1(desc_word1),
		.desc_word2(desc_word2),
		.desc_word3(desc_word3),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.match_query(match_query),
		.match_reference(match_reference),
		.match_distance(match_distance)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver stalls at random with the current phase's probability. One
	// assignment per edge, so the stall never glitches within a time step.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Every accepted match beat is compared with the oldest prediction. The
	// outputs are read at the edge, before any update that the edge causes.
	always @(posedge clk) begin : match_checker
		match_t m;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_matches.size() == 0) begin
				$error("unexpected match beat: query %0d reference %0d distance %0d",
					match_query, match_reference, match_distance);
				fail_count++;
			end else begin
				m = pending_matches.pop_front();
				if (match_query !== m.qidx) begin
					$error("match_query: expected %0d, got %0d", m.qidx, match_query);
					fail_count++;
				end
				if (match_reference !== m.ref_pos) begin
					$error("match_reference: expected %0d, got %0d", m.ref_pos,
						match_reference);
					fail_count++;
				end
				if (match_distance !== m.dist_val) begin
					$error("match_distance: expected %0d, got %0d", m.dist_val,
						match_distance);
					fail_count++;
				end
			end
		end
	end

	// Applies one accepted beat to the mirrored state. A corner query scans the
	// corner references in load order and keeps the first one at the least
	// distance, so ties go to the earliest reference. A match is predicted only
	// when that least distance lies strictly below the threshold.
	function automatic void apply_beat(input logic [OPCODE_W-1:0] op, input logic corner,
			input logic [QIDX_W-1:0] qidx, input logic [DESC_W-1:0] desc);
		int best_dist;
		int best_pos;
		int hd;
		bit found;
		match_t m;
		found = 1'b0;
		best_dist = 0;
		best_pos = 0;
		case (op)
			OP_CLEAR: begin
				mirror_count = 0;
			end
			OP_APPEND: begin
				// A full store silently drops the append.
				if (mirror_count < MAX_REFS) begin
					mirror_desc[mirror_count] = desc;
					mirror_corner[mirror_count] = corner;
					mirror_count++;
				end
			end
			OP_QUERY: begin
				if (corner) begin
					for (int j = 0; j < int'(mirror_count); j++) begin
						if (mirror_corner[j]) begin
							hd = $countones(desc ^ mirror_desc[j]);
							if (!found || hd < best_dist) begin
								found = 1'b1;
								best_dist = hd;
								best_pos = j;
							end
						end
					end
					if (found && best_dist < int'(mirror_threshold)) begin
						m.qidx = qidx;
						m.ref_pos = REF_W'(best_pos);
						m.dist_val = DIST_W'(best_dist);
						pending_matches.insert(pending_matches.size(), m);
					end
				end
			end
			default: begin
				// The reserved opcode leaves the state alone.
			end
		endcase
	endfunction

	// Sends one beat. Any idle cycles come first, with valid low; once valid is
	// up it stays up and the payload holds still until the core takes the beat.
	// The beat counts as taken at the first edge that sees stall low.
	task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic corner,
			input logic [QIDX_W-1:0] qidx, input logic [DESC_W-1:0] desc);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		is_corner <= corner;
		query_index <= qidx;
		desc_word0 <= desc[63:0];
		desc_word1 <= desc[127:64];
		desc_word2 <= desc[191:128];
		desc_word3 <= desc[255:192];
		do @(posedge clk); while (in_stall);
		apply_beat(op, corner, qidx, desc);
	endtask

	// Brings the input side to rest and waits for every predicted match. Queries
	// that find nothing may still sit in the queue or be scanning, so the wait
	// then covers a full scan for the back end and for each queue entry before
	// the core is taken as idle.
	task automatic settle();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_matches.size() != 0 && guard < 100_000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_matches.size() != 0) begin
			$error("%0d match beats never arrived", pending_matches.size());
			fail_count++;
			pending_matches.delete();
		end
		repeat ((QUEUE_DEPTH + 1) * (MAX_REFS + 8)) @(posedge clk);
	endtask

	// One transfer on the configuration port: a setup phase, then an access
	// phase that ends at the first edge with pready high, then the bus returns to idle.
	// A read is checked against the mirrored threshold.
	task automatic apb_transfer(input logic is_write, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (is_write) begin
			if (addr == THRESHOLD_ADDR)
				mirror_threshold = data[THR_W-1:0];
		end else if (prdata !== APB_DATA_W'(mirror_threshold)) begin
			$error("prdata: expected %0d, got %0d", mirror_threshold, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Writes the threshold while the core is idle and reads it back.
	task automatic set_threshold(input logic [APB_DATA_W-1:0] value);
		settle();
		apb_transfer(1'b1, THRESHOLD_ADDR, value);
		apb_transfer(1'b0, THRESHOLD_ADDR, '0);
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		sender_idle_pct = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	function automatic logic [DESC_W-1:0] rand_desc();
		logic [DESC_W-1:0] r;
		for (int i = 0; i < DESC_W / 32; i++)
			r[i*32 +: 32] = $urandom();
		return r;
	endfunction

	function automatic logic [DESC_W-1:0] flip_bits(input logic [DESC_W-1:0] d, input int n);
		for (int i = 0; i < n; i++)
			d[$urandom_range(DESC_W - 1)] ^= 1'b1;
		return d;
	endfunction

	// A descriptor whose low n bits are set and the rest clear.
	function automatic logic [DESC_W-1:0] low_ones(input int n);
		return (n >= DESC_W) ? '1 : ((DESC_W'(1) << n) - DESC_W'(1));
	endfunction

	// Hand-picked beats: empty store, ties, corner flags on both sides, the
	// threshold boundary, the reserved opcode and queries after a clear.
	task automatic test_directed_cases();
		set_idling(0, 0);
		// Right after reset the threshold must read back as its reset value.
		apb_transfer(1'b0, THRESHOLD_ADDR, '0);
		send_beat(OP_QUERY, 1'b1, '0, '0);
		send_beat(OP_APPEND, 1'b1, '0, '0);
		send_beat(OP_APPEND, 1'b0, '0, '1);
		// An exact copy of the first reference, so the two always tie.
		send_beat(OP_APPEND, 1'b1, '0, '0);
		send_beat(OP_APPEND, 1'b1, '0, {4{64'h8000_0000_0000_0001}});
		send_beat(OP_QUERY, 1'b1, '1, '0);
		send_beat(OP_QUERY, 1'b0, 12'h0AB, '0);
		// All ones: the best corner reference is still far above the threshold.
		send_beat(OP_QUERY, 1'b1, 12'h555, '1);
		send_beat(OP_RESERVED, 1'b1, 12'hFFF, '0);
		// Distance one below the reset threshold matches; equal to it does not.
		send_beat(OP_QUERY, 1'b1, 12'h123, low_ones(THRESHOLD_RESET - 1));
		send_beat(OP_QUERY, 1'b1, 12'h321, low_ones(THRESHOLD_RESET));
		send_beat(OP_CLEAR, 1'b1, '1, '1);
		send_beat(OP_QUERY, 1'b1, 12'hAAA, '0);
		// A store holding only a non-corner reference never matches.
		send_beat(OP_APPEND, 1'b0, '0, '0);
		send_beat(OP_QUERY, 1'b1, 12'h800, '0);
		send_beat(OP_APPEND, 1'b1, '0, low_ones(3));
		send_beat(OP_QUERY, 1'b1, 12'h7FF, '0);
		settle();
	endtask

	// Threshold extremes: zero rejects even an exact hit, one accepts only an
	// exact hit, anything above the largest distance accepts every corner query.
	// A write to the unused register address must leave the threshold alone.
	task automatic test_threshold_extremes();
		set_idling(0, 0);
		send_beat(OP_CLEAR, 1'b0, '0, '0);
		send_beat(OP_APPEND, 1'b1, '0, '0);
		set_threshold(32'd0);
		send_beat(OP_QUERY, 1'b1, 12'h001, '0);
		set_threshold(32'd1);
		send_beat(OP_QUERY, 1'b1, 12'h002, '0);
		send_beat(OP_QUERY, 1'b1, 12'h003, low_ones(1));
		send_beat(OP_CLEAR, 1'b0, '0, '0);
		send_beat(OP_APPEND, 1'b1, '0, '1);
		set_threshold(32'd257);
		send_beat(OP_QUERY, 1'b1, 12'h004, '0);
		set_threshold(32'd256);
		send_beat(OP_QUERY, 1'b1, 12'h005, '0);
		// Only the low nine bits of the written word count.
		set_threshold(32'hFFFF_FFFF);
		send_beat(OP_QUERY, 1'b1, 12'h006, '0);
		settle();
		apb_transfer(1'b1, SPARE_ADDR, 32'd0);
		apb_transfer(1'b0, THRESHOLD_ADDR, '0);
		send_beat(OP_QUERY, 1'b1, 12'h007, '0);
		set_threshold(32'd50);
	endtask

	// Loads a longer run of references. The last two are a near copy and then
	// an exact copy of a target descriptor, so the later, closer entry wins.
	task automatic test_long_store();
		logic [DESC_W-1:0] target;
		set_idling(0, 0);
		target = rand_desc();
		send_beat(OP_CLEAR, 1'b0, '0, '0);
		for (int i = 0; i < STORE_FILL - 2; i++)
			send_beat(OP_APPEND, 1'($urandom_range(1)), '0, rand_desc());
		send_beat(OP_APPEND, 1'b1, '0, flip_bits(target, 1));
		send_beat(OP_APPEND, 1'b1, '0, target);
		send_beat(OP_QUERY, 1'b1, 12'hF00, target);
		set_threshold(32'd257);
		send_beat(OP_QUERY, 1'b1, 12'h0F0, '0);
		send_beat(OP_QUERY, 1'b1, 12'h00F, '1);
		send_beat(OP_CLEAR, 1'b0, '0, '0);
		send_beat(OP_APPEND, 1'b1, '0, target);
		send_beat(OP_QUERY, 1'b1, 12'hFFF, target);
		set_threshold(32'd50);
	endtask

	// One random burst: usually a clear, a handful of references scattered
	// around a base descriptor, then queries near that base so that most of
	// them find a match. About one burst in eight is a single random beat with
	// any opcode instead. Returns the number of beats sent, not counting a reserved opcode.
	task automatic random_burst(output int beats);
		logic [DESC_W-1:0] base;
		logic [OPCODE_W-1:0] op;
		int n_refs;
		int n_queries;
		beats = 0;
		base = rand_desc();
		if ($urandom_range(7) == 0) begin
			op = OPCODE_W'($urandom_range(3));
			send_beat(op, 1'($urandom_range(1)), QIDX_W'($urandom()), rand_desc());
			if (op != OP_RESERVED)
				beats = 1;
		end else begin
			if (mirror_count > 150 || $urandom_range(99) < 70) begin
				send_beat(OP_CLEAR, 1'($urandom_range(1)), QIDX_W'($urandom()), rand_desc());
				beats++;
			end
			n_refs = $urandom_range(1, 10);
			for (int i = 0; i < n_refs; i++) begin
				send_beat(OP_APPEND, 1'($urandom_range(99) < 75), QIDX_W'($urandom()),
					flip_bits(base, $urandom_range(60)));
				beats++;
			end
			n_queries = $urandom_range(1, 3);
			for (int i = 0; i < n_queries; i++) begin
				send_beat(OP_QUERY, 1'($urandom_range(99) < 85), QIDX_W'($urandom()),
					flip_bits(base, $urandom_range(40)));
				beats++;
			end
		end
	endtask

	// Random traffic in four idling phases, each with its own threshold.
	task automatic test_random_traffic();
		int total;
		int beats;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_idling(0, 0);
				1: set_idling(HEAVY_PCT, 0);
				2: set_idling(0, HEAVY_PCT);
				default: set_idling(LIGHT_PCT, LIGHT_PCT);
			endcase
			case (phase)
				0: set_threshold(32'd40);
				1: set_threshold($urandom_range(20, 90));
				2: set_threshold(32'd257);
				default: set_threshold({23'($urandom_range(23'h7F_FFFF)), 9'd45});
			endcase
			total = 0;
			while (total < 46) begin
				random_burst(beats);
				total += beats;
			end
		end
		settle();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_threshold_extremes();
		test_long_store();
		test_random_traffic();
		settle();
		if (fail_count == 0)
			$display("hamming_nearest_descriptor_match_core_tb passed");
		else
			$display("hamming_nearest_descriptor_match_core_tb failed");
		$finish;
	end

	// A hung handshake or a lost beat ends the run here.
	initial begin
		#(WATCHDOG_CYCLES * 12);
		$display("hamming_nearest_descriptor_match_core_tb failed");
		$finish;
	end

endmodule

`default_nettype wire

[hamming_nearest_descriptor_match_core.f]
rtl/core/hndm_pkg.sv
rtl/core/hndm_front.sv
rtl/core/hndm_back.sv
rtl/core/hamming_nearest_descriptor_match_core.sv
tb/sv/hamming_nearest_descriptor_match_core_tb.sv
